FILE: src/gblr_pkg.sv
// gblr_pkg: shared constants, types and codes for the line blur block
// used by gblr_lane and gaussian_line_blur_edge_renorm; no dependencies
package gblr_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_TAPS = 15;
    localparam int DEF_CHANNELS = 4;
    localparam int DEF_LINE_MAX = 4096;

    // fixed field widths, lane count and result cap
    localparam int PIX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int LANES   = 4;
    localparam int RESULT_CAP = 8;

    // quotient bits of the edge divider, top bit flags saturation
    localparam int DIV_BITS = 9;

    // round-half-up offset for Q1.15
    localparam int ROUND_HALF = 16384;

    // register indexes of the write port
    localparam logic [1:0] REG_HALF_TAPS = 2'd0;
    localparam logic [1:0] REG_COEF_NEAR = 2'd1;
    localparam logic [1:0] REG_COEF_FAR  = 2'd2;

    // register reset values
    localparam logic [2:0]  RST_HALF_TAPS = 3'd0;
    localparam logic [63:0] RST_COEF_NEAR = 64'd32768;
    localparam logic [63:0] RST_COEF_FAR  = 64'd0;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ACC,
        ST_FIN,
        ST_DIV,
        ST_OUT
    } state_t;

    // how a lane forms its result byte
    typedef enum logic [1:0] {
        RES_ROUND,
        RES_DIV,
        RES_ZERO
    } res_sel_t;

    // control from the sequencer to every lane
    typedef struct packed {
        logic       clr;
        logic       mac;
        logic       div_ld;
        logic       div_step;
        logic [3:0] div_k;
        res_sel_t   sel;
    } lane_ctrl_t;

endpackage

FILE: src/gblr_lane.sv
// gblr_lane: one channel lane, tap accumulator plus bit-serial edge divider
// depends on gblr_pkg
module gblr_lane #(
    parameter int SUM_W   = 28,
    parameter int SCALE_W = 20
) (
    input  logic                         aclk,
    input  gblr_pkg::lane_ctrl_t         ctrl,
    input  logic [gblr_pkg::PIX_W-1:0]   px,
    input  logic [gblr_pkg::COEF_W-1:0]  w,
    input  logic [SCALE_W-1:0]           scale,
    output logic [gblr_pkg::PIX_W-1:0]   res
);

    localparam int NUM_W = SUM_W + 2;
    localparam int RND_W = SUM_W + 1;

    logic [SUM_W-1:0]              sum_reg;
    logic [NUM_W-1:0]              rem_reg;
    logic [gblr_pkg::DIV_BITS-1:0] q_reg;

    logic [NUM_W-1:0] dsh;
    logic             fits;
    logic [RND_W-1:0] rnd;
    logic [RND_W-16:0] rnd_q;

    // shifted divisor 2*scale << k
    assign dsh  = NUM_W'(scale) << (ctrl.div_k + 4'd1);
    assign fits = rem_reg >= dsh;

    // weighted sum over in-line taps
    always_ff @(posedge aclk) begin
        if (ctrl.clr) begin
            sum_reg <= '0;
        end else if (ctrl.mac) begin
            sum_reg <= sum_reg + SUM_W'(w * px);
        end
    end

    // restoring division, one quotient bit per cycle, msb first
    always_ff @(posedge aclk) begin
        if (ctrl.div_ld) begin
            rem_reg <= (NUM_W'(sum_reg) << 1) + NUM_W'(scale);
            q_reg   <= '0;
        end else if (ctrl.div_step) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh;
            end
            q_reg <= {q_reg[gblr_pkg::DIV_BITS-2:0], fits};
        end
    end

    // full-kernel rounding
    assign rnd   = RND_W'(sum_reg) + RND_W'(gblr_pkg::ROUND_HALF);
    assign rnd_q = rnd[RND_W-1:15];

    // result select with clamp
    always_comb begin
        case (ctrl.sel)
            gblr_pkg::RES_ROUND: res = (|rnd_q[RND_W-16:8]) ? 8'hFF : rnd_q[7:0];
            gblr_pkg::RES_DIV:   res = q_reg[8] ? 8'hFF : q_reg[7:0];
            default:             res = '0;
        endcase
    end

endmodule

FILE: src/gaussian_line_blur_edge_renorm.sv
// Streaming 1-D symmetric blur over one image line, four 8-bit channels per
// pixel, one channel lane each, summing one tap per cycle. After a pixel is
// accepted, every blurred pixel it makes due passes a check state, the tap
// loop over the 2*half_taps+1 taps, a finish state, a bit-serial division
// over nine quotient bits when taps fall outside the line and the in-line
// weights are not all zero, and an output state held until the beat is
// taken; one more check closes the item, and no new pixel is taken before
// that. Results trail input by half_taps pixels; the beat with tlast flushes
// the line. No clearing pass follows reset.
// depends on gblr_pkg and gblr_lane
module gaussian_line_blur_edge_renorm #(
    parameter int MAX_TAPS = gblr_pkg::DEF_MAX_TAPS,
    parameter int CHANNELS = gblr_pkg::DEF_CHANNELS,
    parameter int LINE_MAX = gblr_pkg::DEF_LINE_MAX
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // chan_a_in, chan_b_in, chan_c_in, chan_d_in
    input  logic        s_tlast,   // line_end_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // chan_a_out, chan_b_out, chan_c_out, chan_d_out
    output logic        m_tlast    // line_end_out
);

    localparam int CNT_W   = $clog2(LINE_MAX + 1);
    localparam int PW      = CNT_W + 2;
    localparam int IDX_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int HLIM    = (MAX_TAPS - 1) / 2;
    localparam int SUM_W   = $clog2(MAX_TAPS * 65535 * 255 + 1);
    localparam int SCALE_W = $clog2(MAX_TAPS * 65535 + 1);

    gblr_pkg::state_t state_reg, state_next;

    logic [2:0]  half_reg;
    logic [63:0] near_reg, far_reg;
    logic [31:0] win_reg [MAX_TAPS];
    logic [CNT_W-1:0] rcv_reg, em_reg;
    logic        end_reg;
    logic [2:0]  h_reg;
    logic [3:0]  n_reg;
    logic signed [4:0] j_reg;
    logic [3:0]  inside_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [3:0]  step_reg;
    gblr_pkg::res_sel_t sel_reg, sel_next;

    logic [2:0]       h_eff;
    logic [CNT_W-1:0] rcv_a, em_a, rcv_b, em_b;
    logic [CNT_W-1:0] d;
    logic             go;
    logic [PW-1:0]    pos_s;
    logic [CNT_W:0]   pos_u;
    logic             tap_ok;
    logic [IDX_W-1:0] idx;
    logic [4:0]       j_abs;
    logic [2:0]       k;
    logic [15:0]      w;
    logic [31:0]      tap_px;
    logic             full;
    logic             s_acc, m_acc;
    gblr_pkg::lane_ctrl_t ctrl;
    logic [7:0]       lane_res [gblr_pkg::LANES];

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // half width limited by the window
    assign h_eff = (32'(half_reg) < HLIM) ? half_reg : HLIM[2:0];

    // counter update on an accepted beat, over-long lines step back
    always_comb begin
        rcv_a = rcv_reg;
        em_a  = em_reg;
        if (rcv_reg >= CNT_W'(LINE_MAX)) begin
            rcv_a = CNT_W'(LINE_MAX - 1);
            if (em_reg > rcv_a) begin
                em_a = rcv_a;
            end else if (em_reg != '0) begin
                em_a = em_reg - 1'b1;
            end
        end
        rcv_b = rcv_a + 1'b1;
        em_b  = (em_a > rcv_b) ? rcv_b : em_a;
    end

    // distance of the next pending pixel from the newest one
    assign d  = rcv_reg - em_reg - 1'b1;
    assign go = (rcv_reg > em_reg) && (n_reg < 4'(gblr_pkg::RESULT_CAP))
                && (end_reg || (d >= CNT_W'(h_reg)));

    // tap position and in-line test
    assign pos_s  = PW'(d) + {{(PW-5){j_reg[4]}}, j_reg};
    assign pos_u  = pos_s[PW-2:0];
    assign tap_ok = !pos_s[PW-1] && (pos_u < (CNT_W+1)'(MAX_TAPS))
                    && (pos_u < {1'b0, rcv_reg});
    assign idx    = pos_u[IDX_W-1:0];
    assign tap_px = tap_ok ? win_reg[idx] : '0;

    // coefficient of tap distance |j|
    assign j_abs = j_reg[4] ? 5'(-j_reg) : 5'(j_reg);
    assign k     = j_abs[2:0];
    always_comb begin
        case (k[1:0])
            2'd0:    w = k[2] ? far_reg[15:0]  : near_reg[15:0];
            2'd1:    w = k[2] ? far_reg[31:16] : near_reg[31:16];
            2'd2:    w = k[2] ? far_reg[47:32] : near_reg[47:32];
            default: w = k[2] ? far_reg[63:48] : near_reg[63:48];
        endcase
    end

    assign full = inside_reg == {h_reg, 1'b1};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gblr_pkg::ST_IDLE:  if (s_acc) state_next = gblr_pkg::ST_CHECK;
            gblr_pkg::ST_CHECK: state_next = go ? gblr_pkg::ST_ACC : gblr_pkg::ST_IDLE;
            gblr_pkg::ST_ACC: begin
                if (j_reg == $signed({2'b00, h_reg})) state_next = gblr_pkg::ST_FIN;
            end
            gblr_pkg::ST_FIN: begin
                if (full || scale_reg == '0) state_next = gblr_pkg::ST_OUT;
                else                         state_next = gblr_pkg::ST_DIV;
            end
            gblr_pkg::ST_DIV:   if (step_reg == '0) state_next = gblr_pkg::ST_OUT;
            gblr_pkg::ST_OUT:   if (m_tready) state_next = gblr_pkg::ST_CHECK;
            default:            state_next = gblr_pkg::ST_IDLE;
        endcase
    end

    // outputs and lane control
    always_comb begin
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        sel_next      = sel_reg;
        ctrl.clr      = 1'b0;
        ctrl.mac      = 1'b0;
        ctrl.div_ld   = 1'b0;
        ctrl.div_step = 1'b0;
        ctrl.div_k    = step_reg;
        ctrl.sel      = sel_reg;
        unique case (state_reg)
            gblr_pkg::ST_IDLE:  s_tready = 1'b1;
            gblr_pkg::ST_CHECK: ctrl.clr = go;
            gblr_pkg::ST_ACC:   ctrl.mac = tap_ok;
            gblr_pkg::ST_FIN: begin
                if (full) begin
                    sel_next = gblr_pkg::RES_ROUND;
                end else if (scale_reg == '0) begin
                    sel_next = gblr_pkg::RES_ZERO;
                end else begin
                    sel_next    = gblr_pkg::RES_DIV;
                    ctrl.div_ld = 1'b1;
                end
            end
            gblr_pkg::ST_DIV:   ctrl.div_step = 1'b1;
            gblr_pkg::ST_OUT:   m_tvalid = 1'b1;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gblr_pkg::ST_IDLE;
            half_reg  <= gblr_pkg::RST_HALF_TAPS;
            near_reg  <= gblr_pkg::RST_COEF_NEAR;
            far_reg   <= gblr_pkg::RST_COEF_FAR;
            rcv_reg   <= '0;
            em_reg    <= '0;
            n_reg     <= '0;
            sel_reg   <= gblr_pkg::RES_ZERO;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    gblr_pkg::REG_HALF_TAPS: half_reg <= cfg_wdata[2:0];
                    gblr_pkg::REG_COEF_NEAR: near_reg <= cfg_wdata;
                    gblr_pkg::REG_COEF_FAR:  far_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_acc) begin
                rcv_reg <= rcv_b;
                em_reg  <= em_b;
                n_reg   <= '0;
            end
            if (state_reg == gblr_pkg::ST_CHECK && !go && end_reg) begin
                rcv_reg <= '0;
                em_reg  <= '0;
            end
            if (m_acc) begin
                em_reg <= em_reg + 1'b1;
                n_reg  <= n_reg + 1'b1;
            end
        end
    end

    // pixel window and per-pixel working registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            for (int i = MAX_TAPS - 1; i > 0; i--) begin
                win_reg[i] <= win_reg[i-1];
            end
            win_reg[0] <= s_tdata;
            end_reg    <= s_tlast;
            h_reg      <= h_eff;
        end
        if (ctrl.clr) begin
            j_reg      <= -$signed({2'b00, h_reg});
            inside_reg <= '0;
            scale_reg  <= '0;
        end
        if (state_reg == gblr_pkg::ST_ACC) begin
            j_reg <= j_reg + 5'sd1;
            if (tap_ok) begin
                inside_reg <= inside_reg + 1'b1;
                scale_reg  <= scale_reg + SCALE_W'(w);
            end
        end
        if (ctrl.div_ld) begin
            step_reg <= 4'(gblr_pkg::DIV_BITS - 1);
        end else if (ctrl.div_step) begin
            step_reg <= step_reg - 1'b1;
        end
    end

    // channel lanes
    for (genvar c = 0; c < gblr_pkg::LANES; c++) begin : g_lane
        if (c < CHANNELS) begin : g_on
            gblr_lane #(
                .SUM_W   (SUM_W),
                .SCALE_W (SCALE_W)
            ) u_lane (
                .aclk  (aclk),
                .ctrl  (ctrl),
                .px    (tap_px[8*c +: 8]),
                .w     (w),
                .scale (scale_reg),
                .res   (lane_res[c])
            );
        end else begin : g_off
            assign lane_res[c] = '0;
        end
    end

    // merge lane results into the output beat
    assign m_tdata = {lane_res[3], lane_res[2], lane_res[1], lane_res[0]};
    assign m_tlast = end_reg && (d == '0);

endmodule

FILE: src/gblr_checker.sv
// gblr_checker: port-level checks for the line blur block, bound to the top
// depends on gaussian_line_blur_edge_renorm ports only
module gblr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // input and output are never open together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is shown");

    // an accepted pixel first closes the input and shows no result
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("input not closed after accept");

    // no result right out of reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown after reset");

endmodule

bind gaussian_line_blur_edge_renorm gblr_checker u_gblr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: test/tb_gaussian_line_blur_edge_renorm.sv
// testbench for gaussian_line_blur_edge_renorm: streams pixel lines through the
// blur, predicts each blurred pixel in a behavioral model and checks every beat
// depends on gblr_pkg and the gaussian_line_blur_edge_renorm rtl
`timescale 1ns / 100ps

module tb_gaussian_line_blur_edge_renorm;

    localparam int WIN = 15;
    localparam int LMAX = 4096;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 1500;

    typedef struct packed {
        logic [31:0] pix;
        logic        eol;
    } beat_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;

    gaussian_line_blur_edge_renorm i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // model state and register copies
    logic [2:0]  mdl_half;
    logic [63:0] mdl_near;
    logic [63:0] mdl_far;
    logic [31:0] mdl_win [WIN];
    int unsigned mdl_rcvd;
    int unsigned mdl_sent;

    beat_t pending_pixels[$];
    beat_t expected_pixels[$];

    int errors;
    int n_checked;
    int n_sent;
    int n_lines;
    longint cycles;
    bit hold_off;
    int hold_cnt;
    int burst_left;
    int gap_left;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [15:0] tap_weight(int unsigned k);
        if (k < 4) return mdl_near[16*k +: 16];
        return mdl_far[16*(k-4) +: 16];
    endfunction

    // one blurred pixel at distance d from the newest one
    function automatic logic [31:0] blur_at(int unsigned d, int unsigned h);
        longint unsigned sum [4];
        longint unsigned scale;
        longint unsigned v;
        int unsigned n_taps;
        int pos;
        logic [15:0] w;
        logic [31:0] res;
        scale = 0;
        n_taps = 0;
        res = '0;
        for (int c = 0; c < 4; c++) sum[c] = 0;
        for (int j = -int'(h); j <= int'(h); j++) begin
            pos = int'(d) + j;
            if (pos < 0 || pos >= WIN || pos > int'(mdl_rcvd) - 1) continue;
            n_taps++;
            w = tap_weight(j < 0 ? -j : j);
            scale += w;
            for (int c = 0; c < 4; c++) sum[c] += w * mdl_win[pos][8*c +: 8];
        end
        for (int c = 0; c < 4; c++) begin
            if (n_taps == 2*h + 1) v = (sum[c] + 16384) >> 15;
            else if (scale == 0) v = 0;
            else v = (2*sum[c] + scale) / (2*scale);
            res[8*c +: 8] = v > 255 ? 8'd255 : v[7:0];
        end
        return res;
    endfunction

    // advance the model by one pixel and queue what it makes due
    task automatic predict_pixel(beat_t b);
        int unsigned h;
        int unsigned d;
        int n;
        beat_t r;
        h = mdl_half > 7 ? 7 : mdl_half;
        n = 0;
        for (int i = WIN-1; i > 0; i--) mdl_win[i] = mdl_win[i-1];
        mdl_win[0] = b.pix;
        if (mdl_rcvd >= LMAX) begin
            mdl_rcvd = LMAX - 1;
            if (mdl_sent > mdl_rcvd) mdl_sent = mdl_rcvd;
            else if (mdl_sent > 0) mdl_sent--;
        end
        mdl_rcvd++;
        if (mdl_sent > mdl_rcvd) mdl_sent = mdl_rcvd;
        while (mdl_rcvd > mdl_sent && n < gblr_pkg::RESULT_CAP) begin
            d = mdl_rcvd - mdl_sent - 1;
            if (!b.eol && d < h) break;
            r.pix = blur_at(d, h);
            r.eol = b.eol && d == 0;
            expected_pixels.push_back(r);
            mdl_sent++;
            n++;
        end
        if (b.eol) begin
            mdl_rcvd = 0;
            mdl_sent = 0;
        end
    endtask

    // driver: bursts of beats with random gaps; prediction on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_pixel('{pix: s_tdata, eol: s_tlast});
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || pending_pixels.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                end else begin
                    s_tvalid <= 1'b1;
                    {s_tdata, s_tlast} <= pending_pixels.pop_front();
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // receiver stall pattern, with a counted long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_off && hold_cnt < HOLD_CYCLES) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            if (!hold_off) hold_cnt <= 0;
            case (cycles[9:8])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                2'd2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= cycles[2] ^ cycles[0];
            endcase
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        beat_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat data=%h last=%b", m_tdata, m_tlast);
            end else begin
                e = expected_pixels.pop_front();
                n_checked++;
                for (int c = 0; c < 4; c++) begin
                    if (m_tdata[8*c +: 8] !== e.pix[8*c +: 8]) begin
                        errors++;
                        if (errors <= 10)
                            $display("beat %0d chan %0d: expected %0d got %0d",
                                     n_checked, c, e.pix[8*c +: 8], m_tdata[8*c +: 8]);
                    end
                end
                if (m_tlast !== e.eol) begin
                    errors++;
                    if (errors <= 10)
                        $display("beat %0d last: expected %b got %b",
                                 n_checked, e.eol, m_tlast);
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            gblr_pkg::REG_HALF_TAPS: mdl_half = val[2:0];
            gblr_pkg::REG_COEF_NEAR: mdl_near = val;
            default: mdl_far = val;
        endcase
    endtask

    // wait for all queued and expected beats, then let the block settle
    task automatic drain();
        while (pending_pixels.size() != 0 || s_tvalid || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic queue_line(int len, bit extreme);
        beat_t b;
        for (int i = 0; i < len; i++) begin
            b.pix = $urandom;
            if (extreme) b.pix = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
            b.eol = (i == len - 1);
            pending_pixels.push_back(b);
        end
        n_lines++;
    endtask

    function automatic logic [63:0] rand_coefs(bit heavy);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (!heavy) for (int k = 0; k < 4; k++) v[16*k +: 16] = v[16*k +: 16] >> 3;
        return v;
    endfunction

    initial begin
        int len;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = gblr_pkg::REG_HALF_TAPS;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cycles = 0;
        hold_off = 1'b0;
        mdl_half = gblr_pkg::RST_HALF_TAPS;
        mdl_near = gblr_pkg::RST_COEF_NEAR;
        mdl_far = gblr_pkg::RST_COEF_FAR;
        for (int i = 0; i < WIN; i++) mdl_win[i] = '0;
        mdl_rcvd = 0;
        mdl_sent = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset kernel: identity, single-pixel and extreme lines
        queue_line(1, 1);
        queue_line(4, 1);
        drain();

        // widest kernel, all-max weights saturate; short lines force edge division
        write_reg(gblr_pkg::REG_HALF_TAPS, 3'd7);
        write_reg(gblr_pkg::REG_COEF_NEAR, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(gblr_pkg::REG_COEF_FAR, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_line(3, 1);
        queue_line(16, 0);
        drain();

        // zero center weight with nonzero far taps: edge scale can be zero
        write_reg(gblr_pkg::REG_COEF_NEAR, 64'h0);
        write_reg(gblr_pkg::REG_COEF_FAR, 64'h0000_0000_0000_4000);
        queue_line(6, 0);
        drain();

        // long receiver hold-off while the sender keeps offering
        write_reg(gblr_pkg::REG_HALF_TAPS, 3'd2);
        write_reg(gblr_pkg::REG_COEF_NEAR, 64'h0000_1000_3000_4000);
        queue_line(40, 0);
        hold_off = 1'b1;
        wait (hold_cnt == HOLD_CYCLES);
        hold_off = 1'b0;
        drain();

        // random settings with mostly short lines
        while (n_sent < 410) begin
            write_reg(gblr_pkg::REG_HALF_TAPS, $urandom_range(0, 7));
            write_reg(gblr_pkg::REG_COEF_NEAR, rand_coefs($urandom_range(0, 3) == 0));
            write_reg(gblr_pkg::REG_COEF_FAR, rand_coefs($urandom_range(0, 3) == 0));
            for (int l = 0; l < 3; l++) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
                queue_line(len, $urandom_range(0, 7) == 0);
            end
            drain();
        end

        $display("covered %0d lines, %0d pixels in, %0d blurred pixels checked",
                 n_lines, n_sent, n_checked);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", errors);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
